// ----- rtl/sati_pkg.sv -----
// sati_pkg: shared types, codes and constants for the sparse angle table interpolator
// no dependencies
`default_nettype none
package sati_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_STORED  = 2'd0,
		ST_DROPPED = 2'd1,
		ST_FOUND   = 2'd2,
		ST_NODATA  = 2'd3
	} status_t;

	// operation codes
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_STORE,
		S_SCAN,
		S_RD_LO,
		S_RD_HI,
		S_MUL,
		S_DIV_LD,
		S_DIV,
		S_OUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture input item
		logic wr;        // write table entry
		logic scan_clr;  // start neighbor scan
		logic scan_step; // examine one entry
		logic rd_lo;     // read low neighbor
		logic rd_hi;     // read high neighbor (or exact)
		logic mul;       // form products
		logic div_start; // start divider
		logic div_step;  // one divider step
		logic res_load;  // load result register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_query;
		logic scan_done;
		logic div_done;
	} stat_t;

endpackage
`default_nettype wire

// ----- rtl/sati_ctrl.sv -----
// sati_ctrl: sequencing state machine for stores and queries
// depends on sati_pkg
`default_nettype none
module sati_ctrl import sati_pkg::*; (
	input  wire  logic  clk,
	input  wire  logic  arst_n,
	input  wire  logic  in_fire,
	input  wire  logic  out_free,
	input  wire  stat_t st,
	output cmd_t        cmd,
	output logic        busy
);

	state_t state_q, state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE:   if (in_fire) state_n = S_STORE;
			S_STORE:  state_n = st.is_query ? S_SCAN : S_OUT;
			S_SCAN:   if (st.scan_done) state_n = S_RD_LO;
			S_RD_LO:  state_n = S_RD_HI;
			S_RD_HI:  state_n = S_MUL;
			S_MUL:    state_n = S_DIV_LD;
			S_DIV_LD: state_n = S_DIV;
			S_DIV:    if (st.div_done) state_n = S_OUT;
			S_OUT:    if (out_free) state_n = S_IDLE;
			default:  state_n = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				cmd.load = in_fire;
			end
			S_STORE: begin
				cmd.wr = !st.is_query;
				cmd.scan_clr = st.is_query;
			end
			S_SCAN:   cmd.scan_step = 1'b1;
			S_RD_LO:  cmd.rd_lo = 1'b1;
			S_RD_HI:  cmd.rd_hi = 1'b1;
			S_MUL:    cmd.mul = 1'b1;
			S_DIV_LD: cmd.div_start = 1'b1;
			S_DIV:    cmd.div_step = 1'b1;
			S_OUT:    cmd.res_load = out_free;
			default:  cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/sati_dp.sv -----
// sati_dp: table memory, neighbor scan, products and serial divider
// depends on sati_pkg
`default_nettype none
module sati_dp import sati_pkg::*; #(
	parameter int MAX_ANGLE = 90
) (
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  cmd_t               cmd,
	input  wire  logic               op_in,
	input  wire  logic signed [15:0] angle_in,
	input  wire  logic signed [31:0] lift_in,
	input  wire  logic signed [31:0] drag_in,
	output stat_t                    st,
	output status_t                  res_status,
	output logic signed [31:0]       res_lift,
	output logic signed [31:0]       res_drag
);

	localparam int DEPTH = 2 * MAX_ANGLE + 1;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int QW = 49; // dividend bits: |product| < 2^32 * 2^17

	// input capture
	logic op_q;
	logic signed [15:0] ang_q;
	logic signed [31:0] lin_q, din_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_in;
			ang_q <= angle_in;
			lin_q <= lift_in;
			din_q <= drag_in;
		end
	end
	assign st.is_query = op_q;

	// store rounding: nearest degree, halves away from zero
	logic [15:0] mag;
	logic [8:0]  rdeg;
	logic signed [9:0] sdeg;
	logic        in_rng;
	logic [IW-1:0] widx;
	always_comb begin
		mag = ang_q[15] ? 16'(-ang_q) : ang_q;
		rdeg = 9'((17'(mag) + 17'd128) >> 8);
		sdeg = ang_q[15] ? -$signed({1'b0, rdeg}) : $signed({1'b0, rdeg});
		in_rng = (32'(rdeg) <= 32'(MAX_ANGLE));
		widx = IW'(sdeg + 10'(MAX_ANGLE));
	end

	// table: valid bits in flops, data in memory
	logic [DEPTH-1:0] valid_q;
	logic [63:0] mem [DEPTH];
	logic [63:0] rd_s1;
	logic [IW-1:0] raddr;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (cmd.wr && in_rng) valid_q[widx] <= 1'b1;
	end
	always_ff @(posedge clk) begin
		if (cmd.wr && in_rng) mem[widx] <= {din_q, lin_q};
		rd_s1 <= mem[raddr];
	end

	// neighbor scan, one entry a cycle
	logic [CW-1:0] sc_q;
	logic [IW-1:0] lo_q, hi_q, ex_q;
	logic lo_v_q, hi_v_q, ex_v_q;
	logic signed [17:0] pos;
	always_comb pos = 18'(($signed({1'b0, sc_q}) - 18'(MAX_ANGLE)) * 256);
	assign st.scan_done = (sc_q == CW'(DEPTH - 1));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= '0; lo_v_q <= 1'b0; hi_v_q <= 1'b0; ex_v_q <= 1'b0;
			lo_q <= '0; hi_q <= '0; ex_q <= '0;
		end else if (cmd.scan_clr) begin
			sc_q <= '0; lo_v_q <= 1'b0; hi_v_q <= 1'b0; ex_v_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!st.scan_done) sc_q <= sc_q + 1'b1;
			if (valid_q[sc_q[IW-1:0]]) begin
				if (pos == 18'(ang_q)) begin
					ex_v_q <= 1'b1; ex_q <= sc_q[IW-1:0];
				end else if (pos < 18'(ang_q)) begin
					lo_v_q <= 1'b1; lo_q <= sc_q[IW-1:0];
				end else if (!hi_v_q) begin
					hi_v_q <= 1'b1; hi_q <= sc_q[IW-1:0];
				end
			end
		end
	end
	assign raddr = cmd.rd_lo ? lo_q : (ex_v_q ? ex_q : hi_q);

	// neighbor data
	logic signed [31:0] plo_q, pdo_q, phl_q, phd_q;
	always_ff @(posedge clk) begin
		if (cmd.rd_hi) begin
			plo_q <= rd_s1[31:0];
			pdo_q <= rd_s1[63:32];
		end
		if (cmd.mul) begin
			phl_q <= rd_s1[31:0];
			phd_q <= rd_s1[63:32];
		end
	end

	// products (post - pre) * num, num < 2^17
	logic [17:0] num;
	logic [17:0] den;
	always_comb begin
		num = 18'(18'(ang_q) - 18'(($signed({1'b0, lo_q}) - 18'(MAX_ANGLE)) * 256));
		den = 18'({1'b0, hi_q} - {1'b0, lo_q}) << 8;
	end
	logic signed [33:0] dl, dd;
	always_comb begin
		dl = 34'($signed(rd_s1[31:0])) - 34'(plo_q);
		dd = 34'($signed(rd_s1[63:32])) - 34'(pdo_q);
	end
	logic signed [51:0] pl_q, pd_q;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pl_q <= dl * $signed({1'b0, num});
			pd_q <= dd * $signed({1'b0, num});
		end
	end

	// restoring divider on magnitudes, one bit a cycle, both channels
	logic [51:0] ml_q, md_q;
	logic [18:0] rl_q, rd_q;
	logic        nl_q, nd_q;
	logic [5:0]  dc_q;
	logic [18:0] tl, td;
	assign st.div_done = (dc_q == 6'(QW));
	always_comb begin
		tl = {rl_q[17:0], ml_q[QW-1]};
		td = {rd_q[17:0], md_q[QW-1]};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dc_q <= '0;
		else if (cmd.div_start) dc_q <= '0;
		else if (cmd.div_step && !st.div_done) dc_q <= dc_q + 6'd1;
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			nl_q <= pl_q[51]; nd_q <= pd_q[51];
			ml_q <= pl_q[51] ? 52'(-pl_q) : pl_q;
			md_q <= pd_q[51] ? 52'(-pd_q) : pd_q;
			rl_q <= '0; rd_q <= '0;
		end else if (cmd.div_step && !st.div_done) begin
			if (tl >= {1'b0, den}) begin
				rl_q <= tl - {1'b0, den};
				ml_q <= {ml_q[50:0], 1'b1};
			end else begin
				rl_q <= tl;
				ml_q <= {ml_q[50:0], 1'b0};
			end
			if (td >= {1'b0, den}) begin
				rd_q <= td - {1'b0, den};
				md_q <= {md_q[50:0], 1'b1};
			end else begin
				rd_q <= td;
				md_q <= {md_q[50:0], 1'b0};
			end
		end
	end

	// floor quotient and result
	logic signed [33:0] ql, qd;
	always_comb begin
		ql = nl_q ? -34'(ml_q[QW-1:0]) - 34'(rl_q != 0) : 34'(ml_q[QW-1:0]);
		qd = nd_q ? -34'(md_q[QW-1:0]) - 34'(rd_q != 0) : 34'(md_q[QW-1:0]);
	end
	always_comb begin
		res_lift = '0;
		res_drag = '0;
		if (!op_q) begin
			res_status = in_rng ? ST_STORED : ST_DROPPED;
		end else if (ex_v_q) begin
			res_status = ST_FOUND;
			res_lift = phl_q;
			res_drag = phd_q;
		end else if (!lo_v_q || !hi_v_q) begin
			res_status = ST_NODATA;
		end else begin
			res_status = ST_FOUND;
			res_lift = 32'(plo_q + ql);
			res_drag = 32'(pdo_q + qd);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sparse_angle_table_interpolator.sv -----
// sparse_angle_table_interpolator: top level, controller plus datapath
// depends on sati_pkg, sati_ctrl, sati_dp
//
// Keeps a table of lift and drag pairs at whole degrees -MAX_ANGLE..MAX_ANGLE.
// Slave stream s_axis_* carries one item: store (operation 0) or query (1).
// Master stream m_axis_* returns exactly one result item per input item.
// One item is worked at a time; s_axis_tready is high only when idle.
// A store writes its entry and then loads its result into the output
// register; the next item can be accepted once the controller is idle.
// A query scans one table entry per cycle, then does two memory reads,
// a product stage, a divider load and a 49-step serial divider.
// The result is held in an output register; while the receiver stalls,
// one more item is accepted and worked, then waits with its result until
// the output register frees, and nothing new is accepted meanwhile.
// Reset clears all valid marks at once and empties the output register;
// no clearing pass is needed.
`default_nettype none
module sparse_angle_table_interpolator import sati_pkg::*; #(
	parameter int MAX_ANGLE = 90
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire  logic [79:0] s_axis_tdata,  // angle[15:0], lift[47:16], drag[79:48]
	input  wire  logic        s_axis_tuser,  // operation
	output logic              m_axis_tvalid,
	input  wire  logic        m_axis_tready,
	output logic [63:0]       m_axis_tdata,  // out_lift[31:0], out_drag[63:32]
	output logic [1:0]        m_axis_tuser   // status
);

	cmd_t  cmd;
	stat_t st;
	logic  busy, in_fire, out_free;
	status_t res_status;
	logic signed [31:0] res_lift, res_drag;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	sati_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_free, .st, .cmd, .busy
	);

	sati_dp #(.MAX_ANGLE(MAX_ANGLE)) u_dp (
		.clk, .arst_n, .cmd,
		.op_in(s_axis_tuser),
		.angle_in(s_axis_tdata[15:0]),
		.lift_in(s_axis_tdata[47:16]),
		.drag_in(s_axis_tdata[79:48]),
		.st, .res_status, .res_lift, .res_drag
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (cmd.res_load) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			m_axis_tdata <= {res_drag, res_lift};
			m_axis_tuser <= res_status;
		end
	end

	// no new item while busy
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready) else $error("accepted while busy");
	// result load only with free output
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> out_free) else $error("result overwrite");
	// zero payload unless found
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_FOUND) |-> (m_axis_tdata == '0))
		else $error("nonzero payload");

endmodule
`default_nettype wire
